[rtl/tccs_pkg.sv]
// Shared types and constants for the text console with cursor and scroll.
// Screen geometry, cell layout, character codes, command codes and FSM states.
// No dependencies.
package tccs_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;
   localparam int ADDR_W  = $clog2(CELLS);

   // field widths of the stream payloads
   localparam int CMD_W  = 2;
   localparam int CHAR_W = 8;
   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int IDX_W  = 11;
   localparam int CELL_W = 16;
   localparam int ATTR_W = 8;

   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

   localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

   // first cell of the bottom row and the last cell of the screen
   localparam logic [ADDR_W-1:0] BOTTOM_ROW_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
   localparam logic [ADDR_W-1:0] LAST_CELL       = ADDR_W'(CELLS - 1);

   typedef enum logic [CMD_W-1:0] {
      CMD_PUT   = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_SET   = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_FILL,
      ST_IDLE,
      ST_READ,
      ST_SCROLL,
      ST_FLUSH
   } state_type;

   function automatic logic [CELL_W-1:0] blank_cell(input logic [ATTR_W-1:0] attr);
      return {attr, CH_SPACE};
   endfunction

endpackage

[rtl/text_console_cursor_scroll.sv]
// Text console: put character, clear, set cursor and read cell on one screen store.
// Depends on tccs_pkg and tccs_ram.
// Put character, set cursor, clear and out-of-range read answer through the result
// registers; an in-range read cell first reads the screen store (one read port) in ST_READ.
// Throughput: one command per cycle while the result channel is ready (after an in-range
// read cell the next waits out ST_READ), but a clear then sweeps all 2000 cells and a
// scroll copies 1920 cells and blanks 80 before the next beat.
// Reset: synchronous; cursor to 0,0, attribute 0x0F, then a clearing pass that
// blanks the store while no command is taken (configuration writes still are).
module text_console_cursor_scroll (
   input  logic        clock,
   input  logic        reset,
   // command channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // char_code[7:0], column[14:8], row[19:15], zero pad
   input  logic [tccs_pkg::CMD_W-1:0] req_tuser, // cmd
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // cursor_index[10:0], cursor_column[17:11],
                                    // cursor_row[22:18], cell_word[38:23], zero pad
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import tccs_pkg::*;

   // ---------------------------------------------------------------- registers
   state_type            state_ff, state_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]     line_ff, line_in;
   logic [ATTR_W-1:0]    attr_ff;
   logic [ADDR_W-1:0]    fill_ff, fill_in;
   logic [CELL_W-1:0]    fill_value_ff, fill_value_in;
   logic [ADDR_W-1:0]    src_ff, src_in;
   logic                 cp_valid_ff, cp_valid_in;
   logic [ADDR_W-1:0]    cp_addr_ff, cp_addr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]     rsp_idx_ff, rsp_idx_in;
   logic [COL_W-1:0]     rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]     rsp_row_ff, rsp_row_in;
   logic [CELL_W-1:0]    rsp_cell_ff, rsp_cell_in;

   // ---------------------------------------------------------------- beat fields
   cmd_type              cmd;
   logic [CHAR_W-1:0]    char_code;
   logic [COL_W-1:0]     column;
   logic [ROW_W-1:0]     row;
   logic                 req_beat;

   assign cmd       = cmd_type'(req_tuser);
   assign char_code = req_tdata[7:0];
   assign column    = req_tdata[14:8];
   assign row       = req_tdata[19:15];

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_beat   = req_tvalid && req_tready;

   // ---------------------------------------------------------------- screen store
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [CELL_W-1:0]    wr_data;
   logic [ADDR_W-1:0]    rd_addr;
   logic [CELL_W-1:0]    rd_data;

   tccs_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---------------------------------------------------------------- command decode
   logic [ADDR_W-1:0]    cur_addr;
   logic [ADDR_W-1:0]    req_addr;
   logic                 req_in_range;
   logic [COL_W:0]       col_w;
   logic [ROW_W:0]       line_w;
   logic                 put_wr;
   logic [ADDR_W-1:0]    put_addr;
   logic [CELL_W-1:0]    put_data;
   logic                 need_scroll;
   logic [COL_W-1:0]     next_col;
   logic [ROW_W-1:0]     next_line;

   assign cur_addr = ADDR_W'(line_ff) * ADDR_W'(COLUMNS) + ADDR_W'(col_ff);
   assign req_addr = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(column);
   assign req_in_range = (32'(column) < COLUMNS) && (32'(row) < ROWS);

   // cursor movement and cell write of a put character
   always_comb begin
      col_w       = {1'b0, col_ff};
      line_w      = {1'b0, line_ff};
      put_wr      = 1'b0;
      put_addr    = cur_addr;
      put_data    = {attr_ff, char_code};
      need_scroll = 1'b0;
      if (char_code == CH_BS) begin
         if (col_ff != '0) begin
            col_w    = col_w - 1'b1;
            put_wr   = 1'b1;
            put_addr = cur_addr - 1'b1;
            put_data = blank_cell(attr_ff);
         end else if (line_ff != '0) begin
            line_w = line_w - 1'b1;
         end
      end else if (char_code == CH_TAB) begin
         col_w = (col_w + (COL_W+1)'(8)) & ~(COL_W+1)'(7);
      end else if (char_code == CH_CR) begin
         col_w = '0;
      end else if (char_code == CH_LF) begin
         col_w  = '0;
         line_w = line_w + 1'b1;
      end else if (char_code >= CH_SPACE) begin
         put_wr = 1'b1;
         col_w  = col_w + 1'b1;
      end
      if (32'(col_w) >= COLUMNS) begin
         col_w  = '0;
         line_w = line_w + 1'b1;
      end
      if (32'(line_w) >= ROWS) begin
         need_scroll = 1'b1;
         line_w      = (ROW_W+1)'(ROWS - 1);
      end
   end

   // cursor after the command in the current beat
   always_comb begin
      next_col  = col_ff;
      next_line = line_ff;
      case (cmd)
         CMD_PUT: begin
            next_col  = col_w[COL_W-1:0];
            next_line = line_w[ROW_W-1:0];
         end
         CMD_CLEAR: begin
            next_col  = '0;
            next_line = '0;
         end
         CMD_SET: begin
            next_col  = (32'(column) < COLUMNS) ? column : COL_W'(COLUMNS - 1);
            next_line = (32'(row) < ROWS) ? row : ROW_W'(ROWS - 1);
         end
         CMD_READ: begin
            next_col  = col_ff;
            next_line = line_ff;
         end
         default: begin
            next_col  = col_ff;
            next_line = line_ff;
         end
      endcase
   end

   // ---------------------------------------------------------------- control
   always_comb begin
      state_in      = state_ff;
      col_in        = col_ff;
      line_in       = line_ff;
      fill_in       = fill_ff;
      fill_value_in = fill_value_ff;
      src_in        = src_ff;
      cp_valid_in   = 1'b0;
      cp_addr_in    = cp_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_idx_in    = rsp_idx_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_cell_in   = rsp_cell_ff;
      wr_en         = 1'b0;
      wr_addr       = fill_ff;
      wr_data       = fill_value_ff;
      rd_addr       = req_addr;

      // a copy from the scroll sweep lands in the cycle after its read
      if (cp_valid_ff) begin
         wr_en   = 1'b1;
         wr_addr = cp_addr_ff;
         wr_data = rd_data;
      end

      case (state_ff)
         ST_FILL: begin
            wr_en   = 1'b1;
            wr_addr = fill_ff;
            wr_data = fill_value_ff;
            if (fill_ff == LAST_CELL) begin
               state_in = ST_IDLE;
            end else begin
               fill_in = fill_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_beat) begin
               col_in      = next_col;
               line_in     = next_line;
               rsp_idx_in  = IDX_W'(ADDR_W'(next_line) * ADDR_W'(COLUMNS)
                                    + ADDR_W'(next_col));
               rsp_col_in  = next_col;
               rsp_row_in  = next_line;
               rsp_cell_in = '0;
               rsp_valid_in = 1'b1;
               case (cmd)
                  CMD_PUT: begin
                     wr_en   = put_wr;
                     wr_addr = put_addr;
                     wr_data = put_data;
                     if (need_scroll) begin
                        state_in      = ST_SCROLL;
                        src_in        = ADDR_W'(COLUMNS);
                        fill_value_in = blank_cell(attr_ff);
                     end
                  end
                  CMD_CLEAR: begin
                     state_in      = ST_FILL;
                     fill_in       = '0;
                     fill_value_in = blank_cell(attr_ff);
                  end
                  CMD_SET: begin
                     state_in = ST_IDLE;
                  end
                  CMD_READ: begin
                     if (req_in_range) begin
                        rsp_valid_in = 1'b0;
                        state_in     = ST_READ;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_cell_in  = rd_data;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_SCROLL: begin
            rd_addr     = src_ff;
            cp_valid_in = 1'b1;
            cp_addr_in  = src_ff - ADDR_W'(COLUMNS);
            if (src_ff == LAST_CELL) begin
               state_in = ST_FLUSH;
            end else begin
               src_in = src_ff + 1'b1;
            end
         end
         ST_FLUSH: begin
            // last copy is written this cycle, then the bottom row is blanked
            state_in = ST_FILL;
            fill_in  = BOTTOM_ROW_BASE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_FILL;
         col_ff        <= '0;
         line_ff       <= '0;
         fill_ff       <= '0;
         fill_value_ff <= blank_cell(ATTR_RESET);
         cp_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         col_ff        <= col_in;
         line_ff       <= line_in;
         fill_ff       <= fill_in;
         fill_value_ff <= fill_value_in;
         cp_valid_ff   <= cp_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      cp_addr_ff  <= cp_addr_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_cell_ff <= rsp_cell_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_cell_ff, rsp_row_ff, rsp_col_ff, rsp_idx_ff};

   // ---------------------------------------------------------------- registers port
   logic csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= ATTR_RESET;
      end else if (csr_wr && (csr_paddr[2] == 1'b0)) begin
         attr_ff <= csr_pwdata[ATTR_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {{(32-ATTR_W){1'b0}}, attr_ff} : '0;

   // ---------------------------------------------------------------- assertions
   // copies only ever land above the bottom row
   assert property (@(posedge clock) disable iff (reset)
      cp_valid_ff |-> (cp_addr_ff < BOTTOM_ROW_BASE))
      else $error("scroll copy outside the upper rows");

   // the cursor never leaves the screen
   assert property (@(posedge clock) disable iff (reset)
      (32'(col_ff) < COLUMNS) && (32'(line_ff) < ROWS))
      else $error("cursor off screen");

   // a put that leaves the last row parks the cursor on the bottom row and sweeps
   assert property (@(posedge clock) disable iff (reset)
      (req_beat && (cmd == CMD_PUT) && need_scroll) |=>
         ((32'(line_ff) == ROWS - 1) && (state_ff == ST_SCROLL)))
      else $error("scroll not started");

   // a pending read is answered in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("read cell result missing");

   // no command is taken while the store is being swept
   assert property (@(posedge clock) disable iff (reset)
      (cp_valid_ff || (state_ff == ST_FILL)) |-> !req_tready)
      else $error("command taken during sweep");

endmodule

[rtl/tccs_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the screen store. No dependencies.
module tccs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
